// File: hw/rtl/tccf_pkg.sv
// shared types, widths, register indexes and arctangent table of the compass filter
package tccf_pkg;

    localparam int DATA_W     = 16;
    localparam int FILT_W     = 27;
    localparam int ROLL_W     = 16;
    localparam int PITCH_W    = 15;
    localparam int HEAD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int CW         = 34;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Z = 3'd6;

    typedef struct packed {
        logic start;
        logic rotate;
    } cordic_cmd_t;

    function automatic logic signed [CW-1:0] atan_at(input logic [ATAN_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return $signed({4'b0, v});
    endfunction

endpackage

// File: hw/rtl/tccf_channels.sv
// valid/ready channel interfaces for raw samples and filtered results
interface tccf_in_if import tccf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] accel_x;
    logic signed [DATA_W-1:0] accel_y;
    logic signed [DATA_W-1:0] accel_z;
    logic signed [DATA_W-1:0] mag_x;
    logic signed [DATA_W-1:0] mag_y;
    logic signed [DATA_W-1:0] mag_z;

    modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                  output ready);
endinterface

interface tccf_out_if import tccf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FILT_W-1:0]  accel_x_filtered;
    logic signed [FILT_W-1:0]  accel_y_filtered;
    logic signed [FILT_W-1:0]  accel_z_filtered;
    logic signed [FILT_W-1:0]  mag_x_filtered;
    logic signed [FILT_W-1:0]  mag_y_filtered;
    logic signed [FILT_W-1:0]  mag_z_filtered;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [HEAD_W-1:0]  heading_angle;

    modport source (output valid, accel_x_filtered, accel_y_filtered, accel_z_filtered,
                    mag_x_filtered, mag_y_filtered, mag_z_filtered,
                    roll_angle, pitch_angle, heading_angle,
                    input ready);
    modport sink (input valid, accel_x_filtered, accel_y_filtered, accel_z_filtered,
                  mag_x_filtered, mag_y_filtered, mag_z_filtered,
                  roll_angle, pitch_angle, heading_angle,
                  output ready);
endinterface

// File: hw/rtl/tilt_compensated_compass_filter_unit.sv
// Tilt-compensated compass filter: one raw accelerometer and magnetometer sample in, one result
// out. Each channel runs a WINDOW_LENGTH moving average, magnetometer averages get hard-iron
// offset and soft-iron gain, then all six pass an exponential average. Roll, pitch and heading
// come from a single iterative CORDIC unit. An item steps each channel in turn through the one
// shared multiplier, runs five CORDIC passes of CORDIC_STEPS iterations, and uses the multiplier
// again for each gain removal and angle scaling.
// The input is not ready while an item is in work; a finished result waits in the output register
// while the next sample is taken. Configuration is written through cfg_we/cfg_index/cfg_data.
module tilt_compensated_compass_filter_unit import tccf_pkg::*; #(
    parameter int WINDOW_LENGTH = 3,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tccf_in_if.sink               in_ch,
    tccf_out_if.source            out_ch
);

    localparam int WL        = WINDOW_LENGTH;
    localparam int SLOT_W    = (WL > 1) ? $clog2(WL) : 1;
    localparam int FILL_W    = $clog2(WL + 1);
    localparam int MEM_DEPTH = WL * 6;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SUM_W     = $clog2(WL) + 17;
    localparam int DIV_SH    = SUM_W;
    localparam int DIV_MUL   = (2 ** DIV_SH) / WL;
    localparam int AVG_W     = 17;
    localparam int X_W       = 28;
    localparam int PROD_W    = 66;

    localparam logic [2:0] PH_ROLL  = 3'd0;
    localparam logic [2:0] PH_PITCH = 3'd1;
    localparam logic [2:0] PH_ROTP  = 3'd2;
    localparam logic [2:0] PH_ROTR  = 3'd3;
    localparam logic [2:0] PH_HEAD  = 3'd4;

    typedef enum logic [15:0] {
        ST_IDLE = 16'b0000_0000_0000_0001,
        ST_WRD  = 16'b0000_0000_0000_0010,
        ST_SUM  = 16'b0000_0000_0000_0100,
        ST_DIVM = 16'b0000_0000_0000_1000,
        ST_DIVQ = 16'b0000_0000_0001_0000,
        ST_CAL  = 16'b0000_0000_0010_0000,
        ST_CALR = 16'b0000_0000_0100_0000,
        ST_EMA  = 16'b0000_0000_1000_0000,
        ST_EMAR = 16'b0000_0001_0000_0000,
        ST_CST  = 16'b0000_0010_0000_0000,
        ST_CWT  = 16'b0000_0100_0000_0000,
        ST_UMUL = 16'b0000_1000_0000_0000,
        ST_URND = 16'b0001_0000_0000_0000,
        ST_AMUL = 16'b0010_0000_0000_0000,
        ST_ARND = 16'b0100_0000_0000_0000,
        ST_DONE = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg;

    // configuration
    logic [16:0]        alpha_reg;
    logic signed [12:0] off_reg [3];
    logic [15:0]        gain_reg [3];
    logic [16:0]        alpha_eff;

    // sample path
    logic signed [DATA_W-1:0] smp_reg [6];
    logic signed [DATA_W-1:0] win_mem [MEM_DEPTH];
    logic signed [DATA_W-1:0] old_reg;
    logic [ADDR_W-1:0]        win_addr;
    logic [SLOT_W-1:0]        slot_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic signed [SUM_W-1:0]  sum_reg [6];
    logic signed [SUM_W-1:0]  cur_sum_reg;
    logic signed [SUM_W-1:0]  new_sum;
    logic [SUM_W-1:0]         abs_sum;
    logic [16:0]              q0, q_fix;
    logic [SUM_W:0]           rem;
    logic signed [AVG_W-1:0]  avg_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [FILT_W-1:0] smooth_reg [6];
    logic [2:0]               ch_reg;
    logic signed [12:0]       off_sel;
    logic [15:0]              gain_sel;
    logic signed [PROD_W-1:0] cal_sum, ema_sum, ema_q, rnd_sum, cd_q;

    // shared multiplier
    logic signed [CW-1:0]     mul_a;
    logic signed [31:0]       mul_b;
    logic signed [PROD_W-1:0] prod_reg;

    // angle work
    logic [2:0]           ph_reg;
    logic signed [CW-1:0] work_reg, roll_reg, pitch_reg, head_reg, xh_reg, a_reg;
    logic signed [15:0]   cdeg_reg [3];
    logic signed [CW-1:0] ang_sel;

    cordic_cmd_t          cor_cmd;
    logic signed [CW-1:0] cor_x, cor_y, cor_z;
    logic                 cor_done;
    logic signed [CW-1:0] cor_xo, cor_yo, cor_zo;

    // output register
    logic                     out_valid_reg;
    logic signed [FILT_W-1:0] o_filt_reg [6];
    logic signed [15:0]       o_roll_reg, o_head_reg;
    logic signed [14:0]       o_pitch_reg;
    logic                     out_load;

    assign alpha_eff = (alpha_reg > 17'd65536) ? 17'd65536 : alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= 17'd13107;
            off_reg[0]  <= 13'sd20;
            off_reg[1]  <= 13'sd9;
            off_reg[2]  <= -13'sd152;
            gain_reg[0] <= 16'd15974;
            gain_reg[1] <= 16'd15335;
            gain_reg[2] <= 16'd18104;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHA:  alpha_reg   <= cfg_data;
                CFG_OFF_X:  off_reg[0]  <= $signed(cfg_data[12:0]);
                CFG_OFF_Y:  off_reg[1]  <= $signed(cfg_data[12:0]);
                CFG_OFF_Z:  off_reg[2]  <= $signed(cfg_data[12:0]);
                CFG_GAIN_X: gain_reg[0] <= cfg_data[15:0];
                CFG_GAIN_Y: gain_reg[1] <= cfg_data[15:0];
                CFG_GAIN_Z: gain_reg[2] <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign win_addr = ADDR_W'(slot_reg) * ADDR_W'(6) + ADDR_W'(ch_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRD)
        begin
            old_reg           <= win_mem[win_addr];
            win_mem[win_addr] <= smp_reg[ch_reg];
        end
    end

    // window sum, truncating divide by the window length
    always_comb
    begin
        new_sum = sum_reg[ch_reg] + SUM_W'(smp_reg[ch_reg]);
        if (fill_reg == FILL_W'(WL))
        begin
            new_sum = new_sum - SUM_W'(old_reg);
        end
        abs_sum = cur_sum_reg[SUM_W-1] ? SUM_W'(-cur_sum_reg) : SUM_W'(cur_sum_reg);
        q0      = 17'(prod_reg >>> DIV_SH);
        rem     = {1'b0, abs_sum} - (SUM_W + 1)'(q0 * WL);
        q_fix   = (rem >= (SUM_W + 1)'(WL)) ? q0 + 17'd1 : q0;
    end

    always_comb
    begin
        case (ch_reg)
            3'd4:    begin off_sel = off_reg[1]; gain_sel = gain_reg[1]; end
            3'd5:    begin off_sel = off_reg[2]; gain_sel = gain_reg[2]; end
            default: begin off_sel = off_reg[0]; gain_sel = gain_reg[0]; end
        endcase
    end

    always_comb
    begin
        case (ch_reg[1:0])
            2'd1:    ang_sel = pitch_reg;
            2'd2:    ang_sel = head_reg;
            default: ang_sel = roll_reg;
        endcase
    end

    assign cal_sum = prod_reg + 66'sd32;
    assign ema_sum = (PROD_W'(smooth_reg[ch_reg]) <<< 16) + prod_reg + 66'sd32768;
    assign ema_q   = ema_sum >>> 16;
    assign rnd_sum = prod_reg + 66'sd536870912;
    assign cd_q    = (prod_reg + 66'sd2147483648) >>> 32;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DIVM:
            begin
                mul_a = CW'(abs_sum);
                mul_b = 32'(DIV_MUL);
            end
            ST_CAL:
            begin
                if (ch_reg >= 3'd3)
                begin
                    mul_a = CW'(18'(avg_reg) - 18'(off_sel));
                    mul_b = $signed({16'b0, gain_sel});
                end
                else
                begin
                    mul_a = CW'(avg_reg);
                    mul_b = 32'sd256;
                end
            end
            ST_EMA:
            begin
                mul_a = CW'(29'(x_reg) - 29'(smooth_reg[ch_reg]));
                mul_b = $signed({15'b0, alpha_eff});
            end
            ST_UMUL:
            begin
                mul_a = work_reg;
                mul_b = 32'sd652032874;
            end
            ST_AMUL:
            begin
                mul_a = ang_sel;
                mul_b = 32'sd36000;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        cor_cmd.start  = (state_reg == ST_CST);
        cor_cmd.rotate = 1'b0;
        cor_x          = '0;
        cor_y          = '0;
        cor_z          = '0;
        case (ph_reg)
            PH_ROLL:
            begin
                cor_x = CW'(smooth_reg[2]);
                cor_y = CW'(smooth_reg[1]);
            end
            PH_PITCH:
            begin
                cor_x = work_reg;
                cor_y = -CW'(smooth_reg[0]);
            end
            PH_ROTP:
            begin
                cor_cmd.rotate = 1'b1;
                cor_x          = CW'(smooth_reg[3]);
                cor_y          = CW'(smooth_reg[5]);
                cor_z          = -pitch_reg;
            end
            PH_ROTR:
            begin
                cor_cmd.rotate = 1'b1;
                cor_x          = CW'(smooth_reg[4]);
                cor_y          = work_reg;
                cor_z          = roll_reg;
            end
            default:
            begin
                cor_x = xh_reg;
                cor_y = -a_reg;
            end
        endcase
    end

    tccf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cor_cmd),
        .x_in  (cor_x),
        .y_in  (cor_y),
        .z_in  (cor_z),
        .done  (cor_done),
        .x_out (cor_xo),
        .y_out (cor_yo),
        .z_out (cor_zo)
    );

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            ph_reg    <= PH_ROLL;
            slot_reg  <= '0;
            fill_reg  <= '0;
            for (int i = 0; i < 6; i++)
            begin
                sum_reg[i]    <= '0;
                smooth_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        ch_reg    <= '0;
                        state_reg <= ST_WRD;
                    end
                end
                ST_WRD:  state_reg <= ST_SUM;
                ST_SUM:
                begin
                    sum_reg[ch_reg] <= new_sum;
                    state_reg       <= ST_DIVM;
                end
                ST_DIVM: state_reg <= ST_DIVQ;
                ST_DIVQ: state_reg <= ST_CAL;
                ST_CAL:  state_reg <= ST_CALR;
                ST_CALR: state_reg <= ST_EMA;
                ST_EMA:  state_reg <= ST_EMAR;
                ST_EMAR:
                begin
                    if (ema_q > 66'sd67108863)
                    begin
                        smooth_reg[ch_reg] <= 27'sd67108863;
                    end
                    else if (ema_q < -66'sd67108864)
                    begin
                        smooth_reg[ch_reg] <= -27'sd67108864;
                    end
                    else
                    begin
                        smooth_reg[ch_reg] <= FILT_W'(ema_q);
                    end
                    if (ch_reg == 3'd5)
                    begin
                        ch_reg    <= '0;
                        ph_reg    <= PH_ROLL;
                        slot_reg  <= (32'(slot_reg) == WL - 1) ? '0 : slot_reg + 1'b1;
                        if (fill_reg != FILL_W'(WL))
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        state_reg <= ST_CST;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 3'd1;
                        state_reg <= ST_WRD;
                    end
                end
                ST_CST:  state_reg <= ST_CWT;
                ST_CWT:
                begin
                    if (cor_done)
                    begin
                        case (ph_reg) inside
                            PH_ROLL, PH_ROTP: state_reg <= ST_UMUL;
                            PH_PITCH:
                            begin
                                ph_reg    <= PH_ROTP;
                                state_reg <= ST_CST;
                            end
                            PH_ROTR:
                            begin
                                ph_reg    <= PH_HEAD;
                                state_reg <= ST_CST;
                            end
                            default:
                            begin
                                ch_reg    <= '0;
                                state_reg <= ST_AMUL;
                            end
                        endcase
                    end
                end
                ST_UMUL: state_reg <= ST_URND;
                ST_URND:
                begin
                    ph_reg    <= ph_reg + 3'd1;
                    state_reg <= ST_CST;
                end
                ST_AMUL: state_reg <= ST_ARND;
                ST_ARND:
                begin
                    if (ch_reg == 3'd2)
                    begin
                        ch_reg    <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 3'd1;
                        state_reg <= ST_AMUL;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            smp_reg[0] <= in_ch.accel_x;
            smp_reg[1] <= in_ch.accel_y;
            smp_reg[2] <= in_ch.accel_z;
            smp_reg[3] <= in_ch.mag_x;
            smp_reg[4] <= in_ch.mag_y;
            smp_reg[5] <= in_ch.mag_z;
        end
        if (state_reg == ST_SUM)
        begin
            cur_sum_reg <= new_sum;
        end
        if (state_reg == ST_DIVQ)
        begin
            avg_reg <= cur_sum_reg[SUM_W-1] ? -$signed(q_fix) : $signed(q_fix);
        end
        if (state_reg == ST_CALR)
        begin
            x_reg <= (ch_reg >= 3'd3) ? X_W'(cal_sum >>> 6) : X_W'(prod_reg);
        end
        if (state_reg == ST_CWT && cor_done)
        begin
            case (ph_reg)
                PH_ROLL:
                begin
                    roll_reg <= cor_zo;
                    work_reg <= cor_xo;
                end
                PH_PITCH: pitch_reg <= cor_zo;
                PH_ROTP:
                begin
                    xh_reg   <= cor_xo;
                    work_reg <= cor_yo;
                end
                PH_ROTR:  a_reg <= cor_xo;
                default:  head_reg <= cor_zo;
            endcase
        end
        if (state_reg == ST_URND)
        begin
            work_reg <= CW'(rnd_sum >>> 30);
        end
        if (state_reg == ST_ARND)
        begin
            if (cd_q > 66'sd18000)
            begin
                cdeg_reg[ch_reg[1:0]] <= 16'sd18000;
            end
            else if (cd_q < -66'sd18000)
            begin
                cdeg_reg[ch_reg[1:0]] <= -16'sd18000;
            end
            else
            begin
                cdeg_reg[ch_reg[1:0]] <= 16'(cd_q);
            end
        end
        if (out_load)
        begin
            for (int i = 0; i < 6; i++)
            begin
                o_filt_reg[i] <= smooth_reg[i];
            end
            o_roll_reg  <= cdeg_reg[0];
            o_pitch_reg <= PITCH_W'(cdeg_reg[1]);
            o_head_reg  <= cdeg_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign in_ch.ready             = (state_reg == ST_IDLE);
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.accel_x_filtered = o_filt_reg[0];
    assign out_ch.accel_y_filtered = o_filt_reg[1];
    assign out_ch.accel_z_filtered = o_filt_reg[2];
    assign out_ch.mag_x_filtered   = o_filt_reg[3];
    assign out_ch.mag_y_filtered   = o_filt_reg[4];
    assign out_ch.mag_z_filtered   = o_filt_reg[5];
    assign out_ch.roll_angle       = o_roll_reg;
    assign out_ch.pitch_angle      = o_pitch_reg;
    assign out_ch.heading_angle    = o_head_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(state_reg == ST_DONE))
        else $error("result presented without finishing an item");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= FILL_W'(WL)) && (32'(slot_reg) < WL))
        else $error("window slot or fill count out of range");

    a_channel_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMAR) |-> (ch_reg <= 3'd5))
        else $error("channel counter out of range");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.roll_angle >= -16'sd18000 && out_ch.roll_angle <= 16'sd18000
                          && out_ch.heading_angle >= -16'sd18000
                          && out_ch.heading_angle <= 16'sd18000))
        else $error("angle result out of range");

endmodule

// File: hw/rtl/tccf_cordic.sv
// iterative cordic unit, vectoring or rotation, one micro-rotation per cycle
module tccf_cordic import tccf_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cordic_cmd_t          cmd,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output logic                 done,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [CW-1:0] z_out
);

    logic signed [CW-1:0]    x_reg, y_reg, z_reg;
    logic signed [CW-1:0]    x_next, y_next, z_next;
    logic [ATAN_IDX_W-1:0]   it_reg;
    logic                    busy_reg;
    logic                    rot_reg;
    logic                    done_reg;
    logic signed [CW-1:0]    dx, dy, at;

    assign dx = y_reg >>> it_reg;
    assign dy = x_reg >>> it_reg;
    assign at = atan_at(it_reg);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (cmd.start)
        begin
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
            if (cmd.rotate)
            begin
                if (z_in > QUARTER_TURN)
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = z_in - QUARTER_TURN;
                end
                else if (z_in < -QUARTER_TURN)
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = z_in + QUARTER_TURN;
                end
            end
            else
            begin
                z_next = '0;
                if (x_in < 0)
                begin
                    if (y_in >= 0)
                    begin
                        x_next = y_in;
                        y_next = -x_in;
                        z_next = QUARTER_TURN;
                    end
                    else
                    begin
                        x_next = -y_in;
                        y_next = x_in;
                        z_next = -QUARTER_TURN;
                    end
                end
            end
        end
        else if (busy_reg)
        begin
            if (rot_reg)
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
            end
            else if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            else if (y_reg < 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg   <= '0;
            busy_reg <= 1'b0;
            rot_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                it_reg   <= '0;
                busy_reg <= 1'b1;
                rot_reg  <= cmd.rotate;
            end
            else if (busy_reg)
            begin
                if (it_reg == ATAN_IDX_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    it_reg <= it_reg + 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
